/* src/pn2d_pkg.sv */
// Package for the 2-D gradient noise texture core: request and result types
// and the fixed-point constants used by the core and its testbench.
`timescale 1ns / 1ps

package pn2d_pkg;

    localparam int GRID_CELLS_DEF = 16;
    localparam int ONE_Q16        = 65536;
    localparam int GRAD_W         = 32;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    typedef struct packed {
        logic               op;
        logic [16:0]        tex_u;
        logic [16:0]        tex_v;
        logic [6:0]         node_col;
        logic [6:0]         node_row;
        logic signed [15:0] grad_x;
        logic signed [15:0] grad_y;
    } req_t;

    typedef struct packed {
        logic signed [15:0] noise;
        logic [15:0]        shade;
    } result_t;

endpackage

/* src/pn2d_ram.sv */
// Simple dual-port RAM with one write port and one registered read port.
// Used for the gradient table banks; no package dependency.
`timescale 1ns / 1ps

module pn2d_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 81
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/perlin_noise_2d_texture_core.sv */
// Two-dimensional gradient noise texture core: nine-stage pipeline over a
// gradient table split into four RAM banks by node row and column parity.
// Depends on pn2d_pkg and pn2d_ram.
// Throughput: one request per cycle, writes and evaluates alike; busy stays low.
// The four banks give all four cell corners in the same cycle, one read port each.
// The receiver cannot stall; results are shown for one cycle with result_valid.
// Reset clears the pipeline valid bits; the gradient table is not cleared.
`timescale 1ns / 1ps

module perlin_noise_2d_texture_core #(
    parameter int GRID_CELLS = pn2d_pkg::GRID_CELLS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  pn2d_pkg::req_t    req,
    output pn2d_pkg::result_t result,
    output logic              result_valid
);

    import pn2d_pkg::*;

    localparam int CELL_W = (GRID_CELLS > 1) ? $clog2(GRID_CELLS) : 1;
    localparam int HALF   = (GRID_CELLS + 2) / 2;
    localparam int DEPTH  = HALF * HALF;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Stage valid bits
    logic v1_reg, e2_reg, w2_reg, e3_reg, e4_reg, e5_reg, e6_reg, e7_reg, e8_reg, e9_reg;

    // Stage 1: registered request
    req_t req1_reg;

    // Stage 2: cell split
    logic [CELL_W-1:0]  cx2_reg, cy2_reg;
    logic [16:0]        sx2_reg, sy2_reg;
    logic [6:0]         col2_reg, row2_reg;
    logic [GRAD_W-1:0]  wdata2_reg;
    logic [CELL_W-1:0]  cx2_next, cy2_next;
    logic [16:0]        sx2_next, sy2_next;
    logic               wen2_next;

    // Stage 3: squares and RAM output
    logic [16:0]        sx3_reg, sy3_reg;
    logic [33:0]        ssx3_reg, ssy3_reg;
    logic               px3_reg, py3_reg;
    logic [GRAD_W-1:0]  rd [4];

    // Stage 4: partial products
    logic signed [33:0] pdx4_reg [4];
    logic signed [33:0] pdy4_reg [4];
    logic [34:0]        hix4_reg, hiy4_reg;
    logic [33:0]        lox4_reg, loy4_reg;

    // Stage 5: corner dots and weights
    logic signed [18:0] dot5_reg [4];
    logic [16:0]        wx5_reg, wy5_reg;

    // Stage 6: horizontal blend products
    logic signed [38:0] ptop6_reg, pbot6_reg;
    logic signed [18:0] d00_6_reg, d01_6_reg;
    logic [16:0]        wy6_reg;

    // Stage 7, 8
    logic signed [20:0] top7_reg, bot7_reg;
    logic [16:0]        wy7_reg;
    logic signed [39:0] pv8_reg;
    logic signed [20:0] top8_reg;

    // Stage 9: result
    result_t            result9_reg;

    assign busy = 1'b0;

    // Coordinate split into cell index and in-cell fraction.
    function automatic logic [CELL_W+17-1:0] split_coord(input logic [16:0] t);
        logic [16:0] tc;
        logic [23:0] scaled;
        logic [7:0]  c;
        logic [23:0] frac;
        tc = (t > 17'(ONE_Q16)) ? 17'(ONE_Q16) : t;
        scaled = 24'(tc) * 24'(GRID_CELLS);
        c = scaled[23:16];
        if (c > 8'(GRID_CELLS - 1))
        begin
            c = 8'(GRID_CELLS - 1);
        end
        frac = scaled - {c, 16'd0};
        split_coord = {c[CELL_W-1:0], frac[16:0]};
    endfunction

    always_comb
    begin
        {cx2_next, sx2_next} = split_coord(req1_reg.tex_u);
        {cy2_next, sy2_next} = split_coord(req1_reg.tex_v);
        wen2_next = v1_reg && (req1_reg.op == OP_WRITE)
                    && (req1_reg.node_col <= 7'(GRID_CELLS))
                    && (req1_reg.node_row <= 7'(GRID_CELLS));
    end

    // Gradient banks: bank index is {row parity, column parity}.
    logic [15:0] waddr_full;
    assign waddr_full = 16'(row2_reg[6:1]) * 16'(HALF) + 16'(col2_reg[6:1]);

    genvar b;
    generate
        for (b = 0; b < 4; b++)
        begin : g_bank
            logic [CELL_W:0] col_sel, row_sel;
            logic [15:0]     raddr_full;
            logic            bwe;

            assign col_sel = (cx2_reg[0] == b[0]) ? {1'b0, cx2_reg} : {1'b0, cx2_reg} + 1'b1;
            assign row_sel = (cy2_reg[0] == b[1]) ? {1'b0, cy2_reg} : {1'b0, cy2_reg} + 1'b1;
            assign raddr_full = 16'(row_sel >> 1) * 16'(HALF) + 16'(col_sel >> 1);
            assign bwe = w2_reg && (col2_reg[0] == b[0]) && (row2_reg[0] == b[1]);

            pn2d_ram #(
                .WIDTH (GRAD_W),
                .DEPTH (DEPTH)
            ) u_ram (
                .clk   (clk),
                .we    (bwe),
                .waddr (waddr_full[ADDR_W-1:0]),
                .wdata (wdata2_reg),
                .raddr (raddr_full[ADDR_W-1:0]),
                .rdata (rd[b])
            );
        end
    endgenerate

    // Corner c = {row offset, column offset} takes its gradient from the bank
    // whose parity matches that corner.
    logic signed [15:0] cgx [4];
    logic signed [15:0] cgy [4];
    logic signed [17:0] cdx [4];
    logic signed [17:0] cdy [4];
    logic [17:0]        kx, ky;

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            cgx[c] = rd[{py3_reg ^ c[1], px3_reg ^ c[0]}][31:16];
            cgy[c] = rd[{py3_reg ^ c[1], px3_reg ^ c[0]}][15:0];
            cdx[c] = $signed({1'b0, sx3_reg}) - (c[0] ? 18'sd65536 : 18'sd0);
            cdy[c] = $signed({1'b0, sy3_reg}) - (c[1] ? 18'sd65536 : 18'sd0);
        end
        kx = 18'(3 * ONE_Q16) - {sx3_reg, 1'b0};
        ky = 18'(3 * ONE_Q16) - {sy3_reg, 1'b0};
    end

    // Stage 5 combinational: rounding of dots and weights.
    logic signed [34:0] acc [4];
    logic signed [34:0] acc_sh [4];
    logic [51:0]        wsum_x, wsum_y;

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            acc[c]    = 35'(pdx4_reg[c]) + 35'(pdy4_reg[c]) + 35'sd32768;
            acc_sh[c] = acc[c] >>> 16;
        end
        wsum_x = {1'b0, hix4_reg, 16'd0} + 52'(lox4_reg) + 52'h0_0000_8000_0000;
        wsum_y = {1'b0, hiy4_reg, 16'd0} + 52'(loy4_reg) + 52'h0_0000_8000_0000;
    end

    // Stage 7 to 9 combinational rounding.
    logic signed [38:0] rtop, rbot;
    logic signed [39:0] rv;
    logic signed [21:0] value9;
    logic signed [23:0] shade_raw;
    result_t            result9_next;

    always_comb
    begin
        rtop = (ptop6_reg + 39'sd32768) >>> 16;
        rbot = (pbot6_reg + 39'sd32768) >>> 16;
        rv   = (pv8_reg + 40'sd32768) >>> 16;
        value9 = 22'(top8_reg) + rv[21:0];
        shade_raw = (24'(value9) + 24'sd16384) <<< 1;
        if (value9 > 22'sd32767)
        begin
            result9_next.noise = 16'sd32767;
        end
        else if (value9 < -22'sd32768)
        begin
            result9_next.noise = -16'sd32768;
        end
        else
        begin
            result9_next.noise = value9[15:0];
        end
        if (shade_raw > 24'sd65535)
        begin
            result9_next.shade = 16'hFFFF;
        end
        else if (shade_raw < 24'sd0)
        begin
            result9_next.shade = 16'h0000;
        end
        else
        begin
            result9_next.shade = shade_raw[15:0];
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            e2_reg <= 1'b0;
            w2_reg <= 1'b0;
            e3_reg <= 1'b0;
            e4_reg <= 1'b0;
            e5_reg <= 1'b0;
            e6_reg <= 1'b0;
            e7_reg <= 1'b0;
            e8_reg <= 1'b0;
            e9_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start && !busy;
            e2_reg <= v1_reg && (req1_reg.op == OP_EVAL);
            w2_reg <= wen2_next;
            e3_reg <= e2_reg;
            e4_reg <= e3_reg;
            e5_reg <= e4_reg;
            e6_reg <= e5_reg;
            e7_reg <= e6_reg;
            e8_reg <= e7_reg;
            e9_reg <= e8_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        req1_reg <= req;

        cx2_reg    <= cx2_next;
        cy2_reg    <= cy2_next;
        sx2_reg    <= sx2_next;
        sy2_reg    <= sy2_next;
        col2_reg   <= req1_reg.node_col;
        row2_reg   <= req1_reg.node_row;
        wdata2_reg <= {req1_reg.grad_x, req1_reg.grad_y};

        sx3_reg  <= sx2_reg;
        sy3_reg  <= sy2_reg;
        ssx3_reg <= 34'(sx2_reg) * 34'(sx2_reg);
        ssy3_reg <= 34'(sy2_reg) * 34'(sy2_reg);
        px3_reg  <= cx2_reg[0];
        py3_reg  <= cy2_reg[0];

        for (int c = 0; c < 4; c++)
        begin
            pdx4_reg[c] <= 34'(cdx[c]) * 34'(cgx[c]);
            pdy4_reg[c] <= 34'(cdy[c]) * 34'(cgy[c]);
        end
        hix4_reg <= 35'(ssx3_reg[33:16]) * 35'(kx);
        hiy4_reg <= 35'(ssy3_reg[33:16]) * 35'(ky);
        lox4_reg <= 34'(ssx3_reg[15:0]) * 34'(kx);
        loy4_reg <= 34'(ssy3_reg[15:0]) * 34'(ky);

        for (int c = 0; c < 4; c++)
        begin
            dot5_reg[c] <= acc_sh[c][18:0];
        end
        wx5_reg <= wsum_x[48:32];
        wy5_reg <= wsum_y[48:32];

        ptop6_reg <= 39'(dot5_reg[1] - dot5_reg[0]) * 39'($signed({1'b0, wx5_reg}));
        pbot6_reg <= 39'(dot5_reg[3] - dot5_reg[2]) * 39'($signed({1'b0, wx5_reg}));
        d00_6_reg <= dot5_reg[0];
        d01_6_reg <= dot5_reg[2];
        wy6_reg   <= wy5_reg;

        top7_reg <= 21'(d00_6_reg) + rtop[20:0];
        bot7_reg <= 21'(d01_6_reg) + rbot[20:0];
        wy7_reg  <= wy6_reg;

        pv8_reg  <= 40'(bot7_reg - top7_reg) * 40'($signed({1'b0, wy7_reg}));
        top8_reg <= top7_reg;

        result9_reg <= result9_next;
    end

    assign result       = result9_reg;
    assign result_valid = e9_reg;

    // A result only ever follows an accepted evaluate request.
    a_result_from_eval: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start && !busy && (req.op == OP_EVAL), 9))
        else $error("result strobe without a matching evaluate request");

    // Strongly negative noise drives the shade to black.
    a_shade_low: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.noise <= -16'sd16384)) |-> (result.shade == 16'h0000))
        else $error("shade not saturated low");

    // Strongly positive noise drives the shade to white.
    a_shade_high: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.noise >= 16'sd16384)) |-> (result.shade == 16'hFFFF))
        else $error("shade not saturated high");

endmodule

/* sim/tb_perlin_noise_2d_texture_core.sv */
// Testbench for perlin_noise_2d_texture_core: drives gradient writes and noise
// evaluations, predicts each result in fixed point and checks it in order.
// Depends on pn2d_pkg and the core RTL.
`timescale 1ns / 1ps

class noise_scoreboard;
    localparam int CELLS = 16;
    localparam int ROW_NODES = CELLS + 1;

    logic signed [15:0] grad_x_tab [ROW_NODES*ROW_NODES];
    logic signed [15:0] grad_y_tab [ROW_NODES*ROW_NODES];
    pn2d_pkg::result_t expected_results [$];
    int errors;

    function new();
        errors = 0;
    endfunction

    static function longint floor_shift(longint v, int k);
        return v >>> k;
    endfunction

    function longint corner_dot(int col, int row, longint dx, longint dy);
        int idx;
        longint acc;
        idx = row * ROW_NODES + col;
        acc = dx * longint'(grad_x_tab[idx]) + dy * longint'(grad_y_tab[idx]);
        return floor_shift(acc + 32768, 16);
    endfunction

    static function longint smooth_weight(longint s);
        return floor_shift(s * s * (3 * 65536 - 2 * s) + (longint'(1) << 31), 32);
    endfunction

    static function longint blend(longint a0, longint a1, longint w);
        return a0 + floor_shift((a1 - a0) * w + 32768, 16);
    endfunction

    static function void split_coord(logic [16:0] t, output int cell_idx, output longint frac);
        longint scaled;
        longint c;
        scaled = (t > 17'd65536) ? 65536 * CELLS : longint'(t) * CELLS;
        c = scaled >> 16;
        if (c > CELLS - 1)
            c = CELLS - 1;
        cell_idx = int'(c);
        frac = scaled - (c << 16);
    endfunction

    function void note_request(pn2d_pkg::req_t r);
        int cx, cy;
        longint sx, sy, wx, wy, top, bottom, value, nz, sh;
        pn2d_pkg::result_t res;
        if (r.op == pn2d_pkg::OP_WRITE) begin
            if (r.node_col <= CELLS && r.node_row <= CELLS) begin
                grad_x_tab[r.node_row * ROW_NODES + r.node_col] = r.grad_x;
                grad_y_tab[r.node_row * ROW_NODES + r.node_col] = r.grad_y;
            end
            return;
        end
        split_coord(r.tex_u, cx, sx);
        split_coord(r.tex_v, cy, sy);
        wx = smooth_weight(sx);
        wy = smooth_weight(sy);
        top = blend(corner_dot(cx, cy, sx, sy), corner_dot(cx + 1, cy, sx - 65536, sy), wx);
        bottom = blend(corner_dot(cx, cy + 1, sx, sy - 65536),
                       corner_dot(cx + 1, cy + 1, sx - 65536, sy - 65536), wx);
        value = blend(top, bottom, wy);
        nz = value > 32767 ? 32767 : (value < -32768 ? -32768 : value);
        sh = 2 * (value + 16384);
        sh = sh > 65535 ? 65535 : (sh < 0 ? 0 : sh);
        res.noise = nz[15:0];
        res.shade = sh[15:0];
        expected_results.push_back(res);
    endfunction

    function void check_result(pn2d_pkg::result_t got);
        pn2d_pkg::result_t want;
        if (expected_results.size() == 0) begin
            $display("%0t: unexpected result noise=%0d shade=%0d", $time, got.noise, got.shade);
            errors++;
            return;
        end
        want = expected_results.pop_front();
        if (got.noise !== want.noise) begin
            $display("%0t: noise expected %0d actual %0d", $time, want.noise, got.noise);
            errors++;
        end
        if (got.shade !== want.shade) begin
            $display("%0t: shade expected %0d actual %0d", $time, want.shade, got.shade);
            errors++;
        end
    endfunction
endclass

module tb_perlin_noise_2d_texture_core;
    import pn2d_pkg::*;

    localparam int CELLS = 16;
    localparam int LATENCY = 9;
    localparam longint CYCLE_LIMIT = 200000;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    req_t req;
    result_t result;
    logic result_valid;
    longint cycles;
    bit quiet_tail;
    noise_scoreboard sb;

    perlin_noise_2d_texture_core u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .req(req),
        .result(result),
        .result_valid(result_valid)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            sb.check_result(result);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("perlin_noise_2d_texture_core verification failed");
            $finish;
        end
    end

    // Holds the request until it is accepted and leaves start high; a random gap
    // before a request, off in the quiet tail, drops start first.
    task automatic send_request(req_t r);
        int gap;
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        req <= r;
        @(posedge clk);
        while (busy) @(posedge clk);
        sb.note_request(r);
    endtask

    task automatic write_node(int col, int row, logic signed [15:0] gx, logic signed [15:0] gy);
        req_t r;
        r = '0;
        r.op = OP_WRITE;
        r.tex_u = 17'($urandom);
        r.tex_v = 17'($urandom);
        r.node_col = 7'(col);
        r.node_row = 7'(row);
        r.grad_x = gx;
        r.grad_y = gy;
        send_request(r);
    endtask

    task automatic evaluate(logic [16:0] u, logic [16:0] v);
        req_t r;
        r = '0;
        r.op = OP_EVAL;
        r.tex_u = u;
        r.tex_v = v;
        r.node_col = 7'($urandom);
        r.node_row = 7'($urandom);
        r.grad_x = 16'($urandom);
        r.grad_y = 16'($urandom);
        send_request(r);
    endtask

    function automatic logic [16:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return 17'd0;
            1: return 17'd65536;
            2: return 17'($urandom_range(65537, 131071));
            3: return 17'($urandom_range(0, 15) * 4096);
            default: return 17'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic signed [15:0] rand_grad();
        case ($urandom_range(0, 7))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'($urandom);
            default: return 16'(int'($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    initial
    begin
        sb = new();
        cycles = 0;
        quiet_tail = 0;
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every node gets a gradient before any evaluate reads one.
        for (int row = 0; row <= CELLS; row++)
            for (int col = 0; col <= CELLS; col++)
                write_node(col, row, rand_grad(), rand_grad());

        // Directed corners and special cases.
        write_node(0, 0, 16'sh7fff, 16'sh7fff);
        write_node(CELLS, CELLS, -16'sh8000, -16'sh8000);
        write_node(127, 127, 16'sh1234, 16'sh4321);
        write_node(CELLS + 1, 0, 16'sh1111, 16'sh1111);
        write_node(0, CELLS + 1, 16'sh2222, 16'sh2222);
        evaluate(17'd0, 17'd0);
        evaluate(17'd65536, 17'd65536);
        evaluate(17'd65536, 17'd0);
        evaluate(17'd0, 17'd65536);
        evaluate(17'h1ffff, 17'h1ffff);
        evaluate(17'd65535, 17'd65535);
        evaluate(17'd32768, 17'd32768);
        evaluate(17'd4095, 17'd61440);
        evaluate(17'd1, 17'd2048);
        for (int k = 0; k < 4; k++)
            write_node(CELLS, k, 16'sh7fff, -16'sh8000);
        for (int k = 0; k < 4; k++)
            evaluate(17'd65536, 17'(k * 4096 + 2048));

        // The sender holds off until the pipeline has drained.
        start <= 1'b0;
        while (sb.expected_results.size() != 0) @(posedge clk);

        for (int n = 0; n < 1500; n++) begin
            if (n == 1250)
                quiet_tail = 1;
            if ($urandom_range(0, 3) == 0)
                write_node($urandom_range(0, 9) == 0 ? $urandom_range(0, 127)
                                                      : $urandom_range(0, CELLS),
                           $urandom_range(0, CELLS), rand_grad(), rand_grad());
            else
                evaluate(rand_coord(), rand_coord());
        end
        start <= 1'b0;

        while (sb.expected_results.size() != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
        if (sb.errors == 0 && sb.expected_results.size() == 0)
            $display("perlin_noise_2d_texture_core verification clean");
        else
            $display("perlin_noise_2d_texture_core verification failed");
        $finish;
    end
endmodule
